// File: rtl/mbsp_pkg.sv
// Shared types and constants of the MIDI byte stream parser.
`timescale 1ns / 1ps

package mbsp_pkg;

    // Byte classes handed from the front classifier to the back executor
    localparam logic [2:0] CLS_REALTIME    = 3'd0;
    localparam logic [2:0] CLS_SYSEX_START = 3'd1;
    localparam logic [2:0] CLS_SYSEX_END   = 3'd2;
    localparam logic [2:0] CLS_SYS_COMMON  = 3'd3;
    localparam logic [2:0] CLS_CHAN_STATUS = 3'd4;
    localparam logic [2:0] CLS_DATA        = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_MESSAGE  = 2'd1;
    localparam logic [1:0] KIND_REALTIME = 2'd2;

    // Status nibbles of interest
    localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
    localparam logic [3:0] NIB_PROGRAM   = 4'hC;
    localparam logic [3:0] NIB_PRESSURE  = 4'hD;

    // Configuration register indexes
    localparam logic REG_SEQ_MODE = 1'b0;

    typedef struct packed {
        logic [2:0] cls;
        logic [7:0] rx;
    } cmd_t;

    typedef struct packed {
        logic       valid;
        cmd_t       cmd;
    } qhead_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic       act;
    } res_t;

endpackage

// File: rtl/mbsp_front.sv
// Front classifier: sorts each received byte into a command class.
`timescale 1ns / 1ps

module mbsp_front (
    input  logic              in_valid,
    input  logic [7:0]        rx_byte,
    input  logic              q_full,
    output logic              in_stall,
    output logic              push,
    output mbsp_pkg::cmd_t    push_cmd
);
    import mbsp_pkg::*;

    logic [2:0] cls;

    always_comb
    begin
        unique case (rx_byte) inside
            [8'hF8:8'hFF]: cls = CLS_REALTIME;
            8'hF0:         cls = CLS_SYSEX_START;
            8'hF7:         cls = CLS_SYSEX_END;
            [8'hF1:8'hF6]: cls = CLS_SYS_COMMON;
            [8'h80:8'hEF]: cls = CLS_CHAN_STATUS;
            default:       cls = CLS_DATA;
        endcase
    end

    assign in_stall     = q_full;
    assign push         = in_valid && !q_full;
    assign push_cmd.cls = cls;
    assign push_cmd.rx  = rx_byte;

endmodule

// File: rtl/mbsp_queue.sv
// Two-entry command queue between classifier and executor.
`timescale 1ns / 1ps

module mbsp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mbsp_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output logic              full,
    output mbsp_pkg::qhead_t  head
);
    import mbsp_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full       = count_reg[1];
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

endmodule

// File: rtl/mbsp_back.sv
// Back executor: running status, SysEx tracking and result register.
`timescale 1ns / 1ps

module mbsp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mbsp_pkg::qhead_t  head,
    input  logic              seq_mode,
    input  logic              out_stall,
    output logic              pop,
    output logic              out_valid,
    output mbsp_pkg::res_t    res
);
    import mbsp_pkg::*;

    logic [7:0] rs_reg, rs_next;
    logic [6:0] held_reg, held_next;
    logic       cnt_reg, cnt_next;
    logic       sysex_reg, sysex_next;
    logic       valid_reg, valid_next;
    res_t       res_reg, res_next;

    logic       emit;
    logic [6:0] e_d1;
    logic [6:0] e_d2;
    logic [6:0] d;
    logic [3:0] nib;

    assign pop = head.valid && (!valid_reg || !out_stall);
    assign d   = head.cmd.rx[6:0];
    assign nib = rs_reg[7:4];

    always_comb
    begin
        rs_next    = rs_reg;
        held_next  = held_reg;
        cnt_next   = cnt_reg;
        sysex_next = sysex_reg;
        res_next   = '0;
        res_next.act = 1'b1;
        emit       = 1'b0;
        e_d1       = held_reg;
        e_d2       = d;
        case (head.cmd.cls)
            CLS_REALTIME:
            begin
                res_next.kind   = KIND_REALTIME;
                res_next.status = head.cmd.rx;
                res_next.act    = 1'b0;
            end
            CLS_SYSEX_START:
            begin
                sysex_next = 1'b1;
                rs_next    = 8'h00;
                cnt_next   = 1'b0;
            end
            CLS_SYSEX_END:
            begin
                sysex_next = 1'b0;
            end
            CLS_CHAN_STATUS:
            begin
                rs_next  = head.cmd.rx;
                cnt_next = 1'b0;
            end
            CLS_DATA:
            begin
                if (!sysex_reg && rs_reg != 8'h00)
                begin
                    if (nib == NIB_PROGRAM || nib == NIB_PRESSURE)
                    begin
                        held_next = d;
                        emit      = 1'b1;
                        e_d1      = d;
                        e_d2      = 7'd0;
                    end
                    else if (!cnt_reg)
                    begin
                        held_next = d;
                        cnt_next  = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            cnt_next = 1'b0;
            // drop note messages while the sequencer owns the notes
            if (!((nib == NIB_NOTE_ON || nib == NIB_NOTE_OFF) && seq_mode))
            begin
                res_next.kind   = KIND_MESSAGE;
                res_next.status = rs_reg;
                res_next.d1     = e_d1;
                res_next.d2     = e_d2;
            end
        end
        valid_next = pop ? 1'b1 : (valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg    <= 8'h00;
            held_reg  <= 7'd0;
            cnt_reg   <= 1'b0;
            sysex_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                rs_reg    <= rs_next;
                held_reg  <= held_next;
                cnt_reg   <= cnt_next;
                sysex_reg <= sysex_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule

// File: rtl/midi_byte_stream_parser.sv
// Top level of the MIDI byte stream parser with running status.
`timescale 1ns / 1ps

// Channel   | Signals                                   | Direction
// ----------+-------------------------------------------+----------
// input     | in_valid, in_stall, rx_byte               | byte in
// output    | out_valid, out_stall, kind, status_out,   | result out
//           | data_first, data_second, activity         |
// config    | psel, penable, pwrite, paddr, pwdata,     | APB slave
//           | prdata, pready                            |
//
// One byte per cycle sustained while the output is not stalled. An accepted
// request is written into the queue and then popped into the result
// register, which offers its result until it is taken.
// The queue and the result register hold three requests in all. In steady
// flow the queue holds one, so an output stall fills it and the input
// stalls from the following cycle. Reset clears running status,
// held data, SysEx mode, sequencer mode and all valid state.

module midi_byte_stream_parser (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] status_out,
    output logic [6:0] data_first,
    output logic [6:0] data_second,
    output logic       activity,
    // configuration port
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);
    import mbsp_pkg::*;

    logic   seq_mode_reg, seq_mode_next;
    logic   cfg_wr;
    logic   q_full;
    logic   push;
    logic   pop;
    cmd_t   push_cmd;
    qhead_t head;
    res_t   res;

    // Configuration: a single register in the word at byte addresses 0 to 3;
    // writes to any other word are dropped, and only bit 0 is kept.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEQ_MODE);

    always_comb
    begin
        seq_mode_next = cfg_wr ? pwdata[0] : seq_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_mode_reg <= 1'b0;
        end
        else
        begin
            seq_mode_reg <= seq_mode_next;
        end
    end

    assign prdata = (paddr[2] == REG_SEQ_MODE) ? {31'd0, seq_mode_reg} : 32'd0;

    // Front: classify the incoming byte and push it into the queue.
    mbsp_front u_front (
        .in_valid (in_valid),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Queue: decouple the classifier from the executor.
    mbsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .head     (head)
    );

    // Back: advance the parser state and hold the result until taken.
    mbsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .seq_mode  (seq_mode_reg),
        .out_stall (out_stall),
        .pop       (pop),
        .out_valid (out_valid),
        .res       (res)
    );

    assign kind        = res.kind;
    assign status_out  = res.status;
    assign data_first  = res.d1;
    assign data_second = res.d2;
    assign activity    = res.act;

endmodule
